@@ hdl/ddmt_pkg.sv @@
// Shared types, constants and register codes for the drive mixer with encoder trim.
package ddmt_pkg;

   localparam int TIME_BITS = 32;
   localparam int TICK_BITS = 16;
   localparam int DUTY_MAX = 255;
   localparam int BLINK_PERIOD = 1000;
   localparam int BLINK_ON = 500;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [2:0] {
      CSR_STRAIGHT_THR_FLOOR,
      CSR_STEER_DEAD_BAND,
      CSR_FAULT_THROTTLE,
      CSR_CORRECTION_INTERVAL_MS,
      CSR_LINK_TIMEOUT_MS,
      CSR_TRIM_CLAMP,
      CSR_RIGHT_OFFSET,
      CSR_TRIM_INCREMENT
   } ddmt_csr_index_type;

   typedef struct packed {
      logic [7:0]  straight_thr_floor;
      logic [7:0]  steer_dead_band;
      logic [7:0]  fault_throttle;
      logic [15:0] correction_interval_ms;
      logic [15:0] link_timeout_ms;
      logic [5:0]  trim_clamp;
      logic [7:0]  right_offset;
      logic [3:0]  trim_increment;
   } ddmt_cfg_type;

   localparam ddmt_cfg_type CFG_RESET = '{
      straight_thr_floor:     8'd80,
      steer_dead_band:        8'd25,
      fault_throttle:         8'd150,
      correction_interval_ms: 16'd250,
      link_timeout_ms:        16'd300,
      trim_clamp:             6'd15,
      right_offset:           8'd15,
      trim_increment:         4'd1
   };

   typedef struct packed {
      logic              ms_tick;
      logic              left_edge;
      logic              right_edge;
      logic              command_valid;
      logic signed [9:0] throttle;
      logic signed [9:0] steering;
   } ddmt_item_type;

   typedef struct packed {
      logic [7:0]        right_positive_duty;
      logic [7:0]        right_negative_duty;
      logic [7:0]        left_positive_duty;
      logic [7:0]        left_negative_duty;
      logic signed [6:0] trim_value;
      logic              encoder_fault;
      logic              link_lost;
      logic              status_led;
   } ddmt_result_type;

endpackage

@@ hdl/ddmt_csr.sv @@
// Configuration register file, written through the csr channel.
module ddmt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [ddmt_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output ddmt_pkg::ddmt_cfg_type              cfg
);
   import ddmt_pkg::*;

   ddmt_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ddmt_csr_index_type'(csr_index))
            CSR_STRAIGHT_THR_FLOOR:     cfg_in.straight_thr_floor = csr_data[7:0];
            CSR_STEER_DEAD_BAND:        cfg_in.steer_dead_band = csr_data[7:0];
            CSR_FAULT_THROTTLE:         cfg_in.fault_throttle = csr_data[7:0];
            CSR_CORRECTION_INTERVAL_MS: cfg_in.correction_interval_ms = csr_data[15:0];
            CSR_LINK_TIMEOUT_MS:        cfg_in.link_timeout_ms = csr_data[15:0];
            CSR_TRIM_CLAMP:             cfg_in.trim_clamp = csr_data[5:0];
            CSR_RIGHT_OFFSET:           cfg_in.right_offset = csr_data[7:0];
            CSR_TRIM_INCREMENT:         cfg_in.trim_increment = csr_data[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/ddmt_core.sv @@
// Per-sample datapath: time base, tick counters, trim update, mixing and duty split.
module ddmt_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  ddmt_pkg::ddmt_item_type    item,
   input  ddmt_pkg::ddmt_cfg_type     cfg,
   output ddmt_pkg::ddmt_result_type  result
);
   import ddmt_pkg::*;

   localparam logic signed [10:0] DRIVE_LIM = 11'(DUTY_MAX);

   function automatic logic signed [10:0] clamp_drive(input logic signed [10:0] v);
      logic signed [10:0] r;
      if (v > DRIVE_LIM) r = DRIVE_LIM;
      else if (v < -DRIVE_LIM) r = -DRIVE_LIM;
      else r = v;
      return r;
   endfunction

   logic [TIME_BITS-1:0] time_ff, time_in, last_cmd_ff, last_cmd_in;
   logic [TIME_BITS-1:0] last_trim_ff, last_trim_in;
   logic [9:0]           blink_ff, blink_in;
   logic [TICK_BITS-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in, lcnt_inc, rcnt_inc;
   logic signed [6:0]    trim_ff, trim_in, trim_cmd, trim_upd;
   logic signed [8:0]    rdrv_ff, rdrv_in, ldrv_ff, ldrv_in, rdrv_neg, ldrv_neg;
   logic [9:0]           thr_abs, steer_abs;
   logic                 trim_due, run_trim, straight, enc_fault, lost, err_up, err_dn;
   logic signed [TICK_BITS:0] tick_err;
   logic signed [7:0]    trim_sum, lim_pos;
   logic signed [10:0]   thr_w, steer_w, mix_r, mix_l, corr, drv_r, drv_l;

   // time base and edge counters come first in a sample
   always_comb begin
      time_in = item.ms_tick ? time_ff + 1'b1 : time_ff;
      blink_in = blink_ff;
      if (item.ms_tick) begin
         blink_in = (blink_ff == 10'(BLINK_PERIOD - 1)) ? 10'd0 : blink_ff + 1'b1;
      end
      lcnt_inc = (item.left_edge && lcnt_ff != '1) ? lcnt_ff + 1'b1 : lcnt_ff;
      rcnt_inc = (item.right_edge && rcnt_ff != '1) ? rcnt_ff + 1'b1 : rcnt_ff;
   end

   // trim update
   always_comb begin
      thr_abs = item.throttle[9] ? 10'(-item.throttle) : item.throttle;
      steer_abs = item.steering[9] ? 10'(-item.steering) : item.steering;
      trim_due = (time_in - last_trim_ff) >= TIME_BITS'(cfg.correction_interval_ms);
      run_trim = item.command_valid && trim_due;
      straight = (thr_abs > {2'b00, cfg.straight_thr_floor}) &&
                 (steer_abs < {2'b00, cfg.steer_dead_band});
      enc_fault = (lcnt_inc == '0 || rcnt_inc == '0) &&
                  (thr_abs > {2'b00, cfg.fault_throttle});
      tick_err = $signed({1'b0, rcnt_inc}) - $signed({1'b0, lcnt_inc});
      err_up = tick_err > $signed((TICK_BITS + 1)'(1));
      err_dn = tick_err < $signed(-(TICK_BITS + 1)'(1));
      lim_pos = $signed({2'b00, cfg.trim_clamp});
      if (err_up) trim_sum = 8'(trim_ff) + $signed({4'b0000, cfg.trim_increment});
      else if (err_dn) trim_sum = 8'(trim_ff) - $signed({4'b0000, cfg.trim_increment});
      else trim_sum = 8'(trim_ff);
      if (trim_sum > lim_pos) trim_upd = 7'(lim_pos);
      else if (trim_sum < -lim_pos) trim_upd = 7'(-lim_pos);
      else trim_upd = 7'(trim_sum);

      trim_cmd = trim_ff;
      if (run_trim) begin
         trim_cmd = (!straight || enc_fault) ? 7'sd0 : trim_upd;
      end
      lcnt_in = run_trim ? '0 : lcnt_inc;
      rcnt_in = run_trim ? '0 : rcnt_inc;
      last_trim_in = run_trim ? time_in : last_trim_ff;
      last_cmd_in = item.command_valid ? time_in : last_cmd_ff;
   end

   // mixing, correction, link check
   always_comb begin
      thr_w = 11'(item.throttle);
      steer_w = 11'(item.steering);
      mix_r = clamp_drive(thr_w - steer_w);
      mix_l = clamp_drive(thr_w + steer_w);
      corr = item.throttle[9] ? -11'(trim_cmd) : 11'(trim_cmd);
      drv_r = clamp_drive(mix_r - $signed({3'b000, cfg.right_offset}) - corr);
      drv_l = clamp_drive(mix_l + corr);
      lost = (time_in - last_cmd_in) >= TIME_BITS'(cfg.link_timeout_ms);

      rdrv_in = item.command_valid ? 9'(drv_r) : rdrv_ff;
      ldrv_in = item.command_valid ? 9'(drv_l) : ldrv_ff;
      trim_in = trim_cmd;
      if (lost) begin
         rdrv_in = 9'sd0;
         ldrv_in = 9'sd0;
         trim_in = 7'sd0;
      end
      rdrv_neg = -rdrv_in;
      ldrv_neg = -ldrv_in;

      result.right_positive_duty = (rdrv_in > 9'sd0) ? rdrv_in[7:0] : 8'd0;
      result.right_negative_duty = (rdrv_in < 9'sd0) ? rdrv_neg[7:0] : 8'd0;
      result.left_positive_duty = (ldrv_in > 9'sd0) ? ldrv_in[7:0] : 8'd0;
      result.left_negative_duty = (ldrv_in < 9'sd0) ? ldrv_neg[7:0] : 8'd0;
      result.trim_value = trim_in;
      result.encoder_fault = run_trim && straight && enc_fault;
      result.link_lost = lost;
      result.status_led = !lost || (blink_in < 10'(BLINK_ON));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         blink_ff <= '0;
         last_cmd_ff <= '0;
         last_trim_ff <= '0;
         lcnt_ff <= '0;
         rcnt_ff <= '0;
         trim_ff <= '0;
         rdrv_ff <= '0;
         ldrv_ff <= '0;
      end else if (step) begin
         time_ff <= time_in;
         blink_ff <= blink_in;
         last_cmd_ff <= last_cmd_in;
         last_trim_ff <= last_trim_in;
         lcnt_ff <= lcnt_in;
         rcnt_ff <= rcnt_in;
         trim_ff <= trim_in;
         rdrv_ff <= rdrv_in;
         ldrv_ff <= ldrv_in;
      end
   end

   a_fault_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.encoder_fault |=> trim_ff == 7'sd0 && lcnt_ff == '0 && rcnt_ff == '0)
      else $error("encoder fault did not clear trim and counters");

   a_lost_stops: assert property (@(posedge clock) disable iff (reset)
      step && result.link_lost |=> rdrv_ff == 9'sd0 && ldrv_ff == 9'sd0 && trim_ff == 7'sd0)
      else $error("link loss did not stop the drives");

   a_cmd_stamp: assert property (@(posedge clock) disable iff (reset)
      step && item.command_valid |=> last_cmd_ff == time_ff)
      else $error("command time not stamped");

endmodule

@@ hdl/ddmt_obuf.sv @@
// Result register with a skid entry so the input side keeps moving during a stall.
module ddmt_obuf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ddmt_pkg::ddmt_result_type  din,
   output logic                       space,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ddmt_pkg::ddmt_result_type  out_data
);
   import ddmt_pkg::*;

   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in, pop;
   ddmt_result_type out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign pop = out_valid_ff && out_ready;
   assign space = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

   // push only arrives while the skid entry is empty
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_data_in = din;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in front");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into a full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && out_data_ff == $past(skid_data_ff))
      else $error("skid entry lost on drain");

endmodule

@@ hdl/differential_drive_mixer_with_trim.sv @@
// Top level of the differential drive mixer with encoder trim.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | req_tdata, req_tuser = command_valid
//  rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// An accepted item sits in the input register; once the skid entry has room the sample
// datapath runs and writes the result register, which drives rsp_tvalid.
// One item per cycle sustained while rsp_tready is high. In a stall the result register,
// one skid entry and the input register each hold an item; req_tready drops once all
// three are full. Reset is synchronous: all counters, trim and drives go to zero and the
// registers to their defaults. csr_ready is always high.
module differential_drive_mixer_with_trim (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] ms_tick, [1] left_edge, [2] right_edge, [12:3] throttle, [22:13] steering
   input  logic [ddmt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] command_valid
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] right_positive_duty, [15:8] right_negative_duty, [23:16] left_positive_duty,
   // [31:24] left_negative_duty, [38:32] trim_value, [39] encoder_fault,
   // [40] link_lost, [41] status_led
   output logic [ddmt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [ddmt_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ddmt_pkg::*;

   ddmt_cfg_type    cfg;
   ddmt_item_type   item_ff, item_in;
   ddmt_result_type result, rsp_data;
   logic            in_valid_ff, in_valid_in, space, step, accept;

   assign step = in_valid_ff && space;
   assign req_tready = !in_valid_ff || space;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      item_in.ms_tick = req_tdata[0];
      item_in.left_edge = req_tdata[1];
      item_in.right_edge = req_tdata[2];
      item_in.command_valid = req_tuser;
      item_in.throttle = $signed(req_tdata[12:3]);
      item_in.steering = $signed(req_tdata[22:13]);
      if (accept) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   ddmt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ddmt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   ddmt_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .din       (result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {6'b000000, rsp_data.status_led, rsp_data.link_lost,
                       rsp_data.encoder_fault, rsp_data.trim_value,
                       rsp_data.left_negative_duty, rsp_data.left_positive_duty,
                       rsp_data.right_negative_duty, rsp_data.right_positive_duty};

endmodule
